[sv/kmst_pkg.sv]
// ----------------------------------------------------------------------------
// kmst_pkg
// shared constants and helpers of the kruskal spanning tree engine
// ----------------------------------------------------------------------------
package kmst_pkg;

	localparam int DefMaxEdges    = 64;
	localparam int DefMaxVertices = 32;
	localparam int VtxW           = 5;
	localparam int WgtW           = 16;
	localparam int CostW          = 22;
	localparam int RankW          = 3;
	localparam int EdgeW          = 2 * VtxW + WgtW;

	localparam logic signed [CostW-1:0] CostMax = {1'b0, {(CostW-1){1'b1}}};
	localparam logic signed [CostW-1:0] CostMin = {1'b1, {(CostW-1){1'b0}}};
	localparam logic [RankW-1:0]        RankMax = {RankW{1'b1}};

	// x goes strictly before y: weight, then first vertex
	function automatic logic edge_before(input logic [EdgeW-1:0] x, input logic [EdgeW-1:0] y);
		logic signed [WgtW-1:0] wx;
		logic signed [WgtW-1:0] wy;
		wx = x[WgtW-1:0];
		wy = y[WgtW-1:0];
		if (wx != wy)
			return wx < wy;
		return x[EdgeW-1 -: VtxW] < y[EdgeW-1 -: VtxW];
	endfunction

	// saturating add of a weight to the running cost
	function automatic logic [CostW-1:0] cost_add(input logic [CostW-1:0] c,
			input logic [WgtW-1:0] w);
		logic signed [CostW:0] s;
		s = $signed({c[CostW-1], c}) + $signed({{(CostW+1-WgtW){w[WgtW-1]}}, w});
		if (s > $signed({1'b0, CostMax}))
			return CostMax;
		if (s < $signed({1'b1, CostMin}))
			return CostMin;
		return s[CostW-1:0];
	endfunction

endpackage

[sv/kmst_ram.sv]
// ----------------------------------------------------------------------------
// kmst_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module kmst_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

[sv/kruskal_mst_engine.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_engine
// loads weighted edges, sorts them, and runs union-find over them in order
// ----------------------------------------------------------------------------
// usage:
//   a request (vertex_a, vertex_b, edge_weight, last_edge) is taken on a
//   rising edge with start high and busy low. a taken edge is stored in
//   the edge ram; edges beyond MAX_EDGES are dropped. a request with
//   last_edge set closes the graph: busy rises, the stored edges are
//   sorted with an insertion sort over an index ram, then the sets are
//   cleared and each sorted edge is walked: its index and edge are
//   fetched, each endpoint is found by following parent links through
//   the shared set ram, then differing roots are joined and the result is
//   emitted. every stored edge gives one result with out_valid high for
//   one cycle; the receiver cannot stall. last_result marks the final
//   one, after which busy falls and the next edge opens a new graph.
//   find does no path compression; results do not depend on it.
//   reset clears the edge count and the control state; the set store is
//   cleared by the sweep that starts every walk.
// ----------------------------------------------------------------------------
module kruskal_mst_engine
	import kmst_pkg::*;
#(
	parameter int MAX_EDGES    = DefMaxEdges,
	parameter int MAX_VERTICES = DefMaxVertices
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VtxW-1:0]         vertex_a,
	input  logic [VtxW-1:0]         vertex_b,
	input  logic signed [WgtW-1:0]  edge_weight,
	input  logic                    last_edge,
	output logic                    out_valid,
	output logic [VtxW-1:0]         out_vertex_a,
	output logic [VtxW-1:0]         out_vertex_b,
	output logic signed [WgtW-1:0]  out_weight,
	output logic                    in_tree,
	output logic signed [CostW-1:0] running_cost,
	output logic                    last_result
);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int SetW = VA + RankW;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_SRD    = 14'b00000000000010, // read cur edge
		S_SRD2   = 14'b00000000000100, // read order[j-1]
		S_SEDG   = 14'b00000000001000, // read edge of order[j-1]
		S_SCMP   = 14'b00000000010000,
		S_SPUT   = 14'b00000000100000,
		S_CLR    = 14'b00000001000000,
		S_WORD   = 14'b00000010000000, // read order[i]
		S_WEDG   = 14'b00000100000000, // read edge
		S_FA     = 14'b00001000000000, // find a
		S_FB     = 14'b00010000000000, // find b
		S_RK     = 14'b00100000000000, // read rank of root b
		S_JOIN   = 14'b01000000000000,
		S_EMIT   = 14'b10000000000000
	} state_t;

	state_t state_q;

	// edge ram
	logic             e_we;
	logic [EA-1:0]    e_addr;
	logic [EdgeW-1:0] e_wdata, e_rdata;
	// order ram
	logic             o_we;
	logic [EA-1:0]    o_addr;
	logic [EA-1:0]    o_wdata, o_rdata;
	// set ram: parent and rank
	logic             p_we;
	logic [VA-1:0]    p_addr;
	logic [SetW-1:0]  p_wdata, p_rdata;

	kmst_ram #(.Width(EdgeW), .Depth(MAX_EDGES)) u_edge (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
	kmst_ram #(.Width(EA), .Depth(MAX_EDGES)) u_order (
		.clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata));
	kmst_ram #(.Width(SetW), .Depth(MAX_VERTICES)) u_set (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));

	logic [CW-1:0]    count_q;   // stored edges
	logic [CW-1:0]    i_q;       // outer index
	logic [CW-1:0]    j_q;       // insertion slot
	logic [EA-1:0]    prev_q;    // order[j-1]
	logic [EdgeW-1:0] cur_q;     // edge being inserted / walked
	logic [VA-1:0]    node_q;    // find pointer / clear index
	logic             wait_q;    // ram read in flight
	logic [VA-1:0]    ra_q, rb_q;
	logic [RankW-1:0] rka_q;
	logic             join_q;
	logic             rk_eq_q;   // roots of equal rank
	logic [CostW-1:0] cost_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// endpoint to set index, as a constant table over all vertex codes
	function automatic logic [VA-1:0] vmod(input logic [VtxW-1:0] v);
		logic [VA-1:0] r;
		r = '0;
		for (int k = 0; k < (1 << VtxW); k++)
			if (32'(v) == k)
				r = VA'(k % MAX_VERTICES);
		return r;
	endfunction

	// ram port muxing
	always_comb begin
		e_we    = 1'b0;
		e_addr  = i_q[EA-1:0];
		e_wdata = {vertex_a, vertex_b, edge_weight};
		o_we    = 1'b0;
		o_addr  = i_q[EA-1:0];
		o_wdata = i_q[EA-1:0];
		p_we    = 1'b0;
		p_addr  = node_q;
		p_wdata = {node_q, {RankW{1'b0}}};
		unique case (state_q)
			S_IDLE: begin
				e_we   = accept && (32'(count_q) < MAX_EDGES);
				e_addr = count_q[EA-1:0];
			end
			S_SRD:  e_addr = i_q[EA-1:0];
			S_SRD2: o_addr = EA'(j_q - CW'(1));
			S_SEDG: e_addr = prev_q;
			S_SCMP: e_addr = prev_q;
			S_SPUT: begin
				o_we   = 1'b1;
				o_addr = j_q[EA-1:0];
				o_wdata = (j_q != '0 && edge_before(cur_q, e_rdata)) ? prev_q : i_q[EA-1:0];
			end
			S_CLR:  p_we = 1'b1;
			S_WORD: o_addr = i_q[EA-1:0];
			S_WEDG: e_addr = o_rdata;
			S_FA, S_FB, S_RK: p_addr = node_q;
			S_JOIN: begin
				p_we = join_q;
				if (rka_q > p_rdata[RankW-1:0]) begin
					p_addr  = rb_q;
					p_wdata = {ra_q, p_rdata[RankW-1:0]};
				end else if (rka_q < p_rdata[RankW-1:0]) begin
					p_addr  = ra_q;
					p_wdata = {rb_q, rka_q};
				end else begin
					p_addr  = rb_q;
					p_wdata = {ra_q, p_rdata[RankW-1:0]};
				end
			end
			S_EMIT: begin
				// equal-rank case: bump rank of root a
				p_we    = join_q && rk_eq_q && (rka_q != RankMax);
				p_addr  = ra_q;
				p_wdata = {ra_q, rka_q + RankW'(1)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
			wait_q    <= 1'b0;
			cost_q    <= '0;
		end else begin
			out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= (32'(count_q) < MAX_EDGES) ? count_q + CW'(1) : count_q;
						if (last_edge) begin
							i_q     <= '0;
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					// insertion of edge i starts with j = i
					j_q <= i_q;
					if (i_q == count_q) begin
						node_q  <= '0;
						state_q <= S_CLR;
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else begin
						wait_q  <= 1'b0;
						cur_q   <= e_rdata;
						state_q <= (i_q == '0) ? S_SPUT : S_SRD2;
					end
				end
				S_SRD2: begin
					if (!wait_q) wait_q <= 1'b1;
					else begin
						wait_q  <= 1'b0;
						prev_q  <= o_rdata;
						state_q <= S_SEDG;
					end
				end
				S_SEDG: state_q <= S_SCMP;
				S_SCMP: state_q <= S_SPUT;
				S_SPUT: begin
					if (j_q != '0 && edge_before(cur_q, e_rdata)) begin
						j_q     <= j_q - CW'(1);
						state_q <= (j_q == CW'(1)) ? S_SPUT : S_SRD2;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_CLR: begin
					node_q <= node_q + VA'(1);
					if (32'(node_q) == MAX_VERTICES - 1) begin
						i_q     <= '0;
						cost_q  <= '0;
						state_q <= (count_q == '0) ? S_IDLE : S_WORD;
					end
				end
				S_WORD: begin
					if (!wait_q) wait_q <= 1'b1;
					else begin
						wait_q  <= 1'b0;
						state_q <= S_WEDG;
					end
				end
				S_WEDG: begin
					if (!wait_q) wait_q <= 1'b1;
					else begin
						wait_q  <= 1'b0;
						cur_q   <= e_rdata;
						node_q  <= vmod(e_rdata[EdgeW-1 -: VtxW]);
						state_q <= S_FA;
					end
				end
				S_FA: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (p_rdata[SetW-1 -: VA] != node_q) begin
						wait_q <= 1'b0;
						node_q <= p_rdata[SetW-1 -: VA];
					end else begin
						wait_q  <= 1'b0;
						ra_q    <= node_q;
						rka_q   <= p_rdata[RankW-1:0];
						node_q  <= vmod(cur_q[EdgeW-VtxW-1 -: VtxW]);
						state_q <= S_FB;
					end
				end
				S_FB: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (p_rdata[SetW-1 -: VA] != node_q) begin
						wait_q <= 1'b0;
						node_q <= p_rdata[SetW-1 -: VA];
					end else begin
						wait_q  <= 1'b0;
						rb_q    <= node_q;
						join_q  <= (node_q != ra_q);
						state_q <= S_RK;
					end
				end
				S_RK: state_q <= S_JOIN; // rank of root b now on p_rdata
				S_JOIN: begin
					if (join_q)
						cost_q <= cost_add(cost_q, cur_q[WgtW-1:0]);
					rk_eq_q <= (rka_q == p_rdata[RankW-1:0]);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					out_valid <= 1'b1;
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) == count_q) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else
						state_q <= S_WORD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result registers, loaded with the strobe
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			out_vertex_a <= cur_q[EdgeW-1 -: VtxW];
			out_vertex_b <= cur_q[EdgeW-VtxW-1 -: VtxW];
			out_weight   <= cur_q[WgtW-1:0];
			in_tree      <= join_q;
			running_cost <= cost_q;
			last_result  <= (i_q + CW'(1) == count_q);
		end
	end
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the kruskal spanning tree engine against a software prediction of
// the sorted walk; edge requests go in with random gaps, results are checked
// field by field as they stream out
// ----------------------------------------------------------------------------
module testbench
	import kmst_pkg::*;
;

	localparam int NumEdges = 64;
	localparam int NumVerts = 32;

	typedef struct {
		logic [VtxW-1:0]         va;
		logic [VtxW-1:0]         vb;
		logic signed [WgtW-1:0]  w;
		logic                    joined;
		logic signed [CostW-1:0] cost;
		logic                    last;
	} tree_step_t;

	// scoreboard: holds the edges of the open graph and the expected walk
	class mst_scoreboard;
		logic [VtxW-1:0]        ea [NumEdges];
		logic [VtxW-1:0]        eb [NumEdges];
		logic signed [WgtW-1:0] ew [NumEdges];
		int                     count;
		tree_step_t             walk_q[$];
		int                     errors;
		int                     checked;

		function new();
			count = 0;
			errors = 0;
			checked = 0;
		endfunction

		// strict order: weight, then first vertex
		function bit goes_first(int x, int y);
			if (ew[x] != ew[y])
				return ew[x] < ew[y];
			return ea[x] < ea[y];
		endfunction

		function int root_of(ref int parent[NumVerts], input int v);
			int r;
			r = v % NumVerts;
			while (parent[r] != r)
				r = parent[r];
			return r;
		endfunction

		function void note_edge(logic [VtxW-1:0] a, logic [VtxW-1:0] b,
				logic signed [WgtW-1:0] w, logic last);
			int                      order[NumEdges];
			int                      parent[NumVerts];
			int                      rank[NumVerts];
			int                      j;
			int                      ra;
			int                      rb;
			logic signed [CostW-1:0] cost;
			logic signed [CostW:0]   s;
			tree_step_t              st;
			if (count < NumEdges) begin
				ea[count] = a;
				eb[count] = b;
				ew[count] = w;
				count++;
			end
			if (!last)
				return;
			// stable insertion sort of the stored edges
			for (int i = 0; i < count; i++) begin
				j = i;
				while (j > 0 && goes_first(i, order[j-1])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
			end
			for (int v = 0; v < NumVerts; v++) begin
				parent[v] = v;
				rank[v] = 0;
			end
			cost = '0;
			for (int i = 0; i < count; i++) begin
				ra = root_of(parent, ea[order[i]]);
				rb = root_of(parent, eb[order[i]]);
				st.joined = (ra != rb);
				if (st.joined) begin
					s = cost + ew[order[i]];
					if (s > CostMax)
						cost = CostMax;
					else if (s < CostMin)
						cost = CostMin;
					else
						cost = s[CostW-1:0];
					// union by rank, rank saturating
					if (rank[ra] > rank[rb])
						parent[rb] = ra;
					else if (rank[ra] < rank[rb])
						parent[ra] = rb;
					else begin
						parent[rb] = ra;
						if (rank[ra] < RankMax)
							rank[ra]++;
					end
				end
				st.va = ea[order[i]];
				st.vb = eb[order[i]];
				st.w = ew[order[i]];
				st.cost = cost;
				st.last = (i == count - 1);
				walk_q = {walk_q, st};
			end
			count = 0;
		endfunction

		function void check_result(tree_step_t got);
			tree_step_t exp;
			if (walk_q.size() == 0) begin
				$error("result with nothing expected: a=%0d b=%0d w=%0d",
					got.va, got.vb, got.w);
				errors++;
				return;
			end
			exp = walk_q.pop_front();
			checked++;
			if (got.va !== exp.va) begin
				$error("out_vertex_a expected %0d actual %0d", exp.va, got.va);
				errors++;
			end
			if (got.vb !== exp.vb) begin
				$error("out_vertex_b expected %0d actual %0d", exp.vb, got.vb);
				errors++;
			end
			if (got.w !== exp.w) begin
				$error("out_weight expected %0d actual %0d", exp.w, got.w);
				errors++;
			end
			if (got.joined !== exp.joined) begin
				$error("in_tree expected %0d actual %0d", exp.joined, got.joined);
				errors++;
			end
			if (got.cost !== exp.cost) begin
				$error("running_cost expected %0d actual %0d", exp.cost, got.cost);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last_result expected %0d actual %0d", exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [VtxW-1:0]         vertex_a;
	logic [VtxW-1:0]         vertex_b;
	logic signed [WgtW-1:0]  edge_weight;
	logic                    last_edge;
	logic                    out_valid;
	logic [VtxW-1:0]         out_vertex_a;
	logic [VtxW-1:0]         out_vertex_b;
	logic signed [WgtW-1:0]  out_weight;
	logic                    in_tree;
	logic signed [CostW-1:0] running_cost;
	logic                    last_result;

	mst_scoreboard sb = new();
	int            edges_sent;
	int            graphs_sent;

	kruskal_mst_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.edge_weight  (edge_weight),
		.last_edge    (last_edge),
		.out_valid    (out_valid),
		.out_vertex_a (out_vertex_a),
		.out_vertex_b (out_vertex_b),
		.out_weight   (out_weight),
		.in_tree      (in_tree),
		.running_cost (running_cost),
		.last_result  (last_result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// results cannot be held off, so every strobe is checked as it comes
	always @(posedge clk) begin
		tree_step_t got;
		if (arst_n && out_valid) begin
			got.va = out_vertex_a;
			got.vb = out_vertex_b;
			got.w = out_weight;
			got.joined = in_tree;
			got.cost = running_cost;
			got.last = last_result;
			sb.check_result(got);
		end
	end

	// one edge request; start stays high across back-to-back requests
	task automatic send_edge(input int a, input int b, input int w, input bit last,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		vertex_a <= a[VtxW-1:0];
		vertex_b <= b[VtxW-1:0];
		edge_weight <= w[WgtW-1:0];
		last_edge <= last;
		do @(posedge clk); while (busy);
		sb.note_edge(a[VtxW-1:0], b[VtxW-1:0], w[WgtW-1:0], last);
		edges_sent++;
		if (last)
			graphs_sent++;
	endtask

	// random graph: vertex span and weight span control cycles and ties
	task automatic send_graph(input int n, input int vmax, input int wspan, input bit burst);
		int w;
		for (int i = 0; i < n; i++) begin
			if (wspan == 0)
				w = $urandom;
			else
				w = $urandom_range(0, wspan) - wspan / 2;
			send_edge($urandom_range(0, vmax), $urandom_range(0, vmax), w, i == n - 1,
				burst ? 0 : $urandom_range(0, 15));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		vertex_a = '0;
		vertex_b = '0;
		edge_weight = '0;
		last_edge = 1'b0;
		edges_sent = 0;
		graphs_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single edge graph, extreme vertices and weights
		send_edge(31, 0, 32767, 1, 0);
		send_edge(0, 31, -32768, 1, 3);
		// self loop never enters the tree
		send_edge(5, 5, -100, 0, 0);
		send_edge(5, 6, 10, 1, 0);
		// ties on weight: first vertex decides, then load order
		send_edge(9, 1, 7, 0, 2);
		send_edge(3, 4, 7, 0, 0);
		send_edge(3, 1, 7, 0, 0);
		send_edge(3, 9, 7, 0, 1);
		send_edge(1, 4, 7, 1, 0);
		// cycle closes: last edge rejected
		send_edge(1, 2, -5, 0, 0);
		send_edge(2, 3, -5, 0, 0);
		send_edge(3, 1, -5, 1, 0);
		// store full: excess edges dropped, the closing one still starts the walk
		for (int i = 0; i < 70; i++)
			send_edge($urandom_range(0, 31), $urandom_range(0, 31),
				(i % 2) ? 32767 : -32768 + i, i == 69, 0);

		// random graphs, mostly small, a few overfull
		while (edges_sent < 410) begin
			case ($urandom_range(0, 9))
				0: send_graph($urandom_range(60, 68), 31, 0, $urandom_range(0, 1));
				1, 2: send_graph($urandom_range(1, 12), 31, 0, 0);
				3, 4: send_graph($urandom_range(2, 12), 7, 8, 0);
				5: send_graph($urandom_range(1, 12), 3, 3, 1);
				default: send_graph($urandom_range(1, 16), 15, 200, $urandom_range(0, 1));
			endcase
		end
		start <= 1'b0;

		wait (sb.walk_q.size() == 0);
		repeat (100) @(posedge clk);
		$display("%0d edge requests in %0d graphs, %0d results checked",
			edges_sent, graphs_sent, sb.checked);
		if (sb.errors == 0 && sb.walk_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// overall time limit
	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
sv/kmst_pkg.sv
sv/kmst_ram.sv
sv/kruskal_mst_engine.sv
sim/testbench.sv
